// ===== rtl/rtm_pkg.sv =====
// rtm_pkg: shared types, constants and the sine table builder for the tone mixer
// used by rtm_tone_gen, rtm_mix_lane and reference_tone_mixer; depends on nothing
`timescale 1ns / 1ps

package rtm_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TONE_ENABLE = 1'b0,
        REG_MUTE_OUTPUT = 1'b1
    } cfg_reg_t;

    // per-word mode flags that travel down the pipeline
    typedef struct packed {
        logic tone_en;
        logic mute;
    } mix_ctrl_t;

    localparam int PHASE_W = 32;

    // gains in Q0.16
    localparam logic [16:0] MIX_GAIN_Q16  = 17'd36045;
    localparam logic [15:0] TONE_GAIN_Q16 = 16'd5243;

    // sine series constants in Q2.30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // quarter-wave table entry k of 2^bits, scaled by the tone gain, in a width-bit sample
    function automatic logic [63:0] tone_entry(input int k, input int bits, input int width);
        logic        [63:0] x;
        logic        [63:0] x2;
        logic        [63:0] term;
        logic signed [63:0] sum;
        logic        [63:0] s;
        logic        [63:0] g;
        x    = (HALF_PI_Q30 * 64'(k)) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 10; n++)
        begin
            // divisor (2n)(2n+1) of the Taylor term
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            s = 64'd0;
        else if ($unsigned(sum) > ONE_Q30)
            s = ONE_Q30;
        else
            s = $unsigned(sum);
        g = (s * 64'(TONE_GAIN_Q16) + 64'd32768) >> 16;
        return (g + (64'd1 << (30 - width))) >> (31 - width);
    endfunction

endpackage

// ===== rtl/rtm_tone_gen.sv =====
// rtm_tone_gen: phase accumulator and quarter-wave sine lookup with registered read
// depends on rtm_pkg for the table builder and the phase width
`timescale 1ns / 1ps

module rtm_tone_gen
    import rtm_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int SAMPLE_WIDTH     = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           accept,
    input  logic                           tone_enable,
    input  logic [PHASE_W-1:0]             tone_step,
    output logic signed [SAMPLE_WIDTH-1:0] tone
);

    localparam int DEPTH_BITS = $clog2(SINE_TABLE_DEPTH + 1) - 1;
    localparam int DEPTH      = 1 << DEPTH_BITS;
    localparam int ADDR_W     = DEPTH_BITS + 1;
    localparam int MAG_W      = SAMPLE_WIDTH - 3;

    logic [PHASE_W-1:0]    phase_reg;
    logic [PHASE_W-1:0]    phase_next;
    logic [DEPTH_BITS-1:0] index;
    logic [ADDR_W-1:0]     addr_next;
    logic [ADDR_W-1:0]     addr_reg;
    logic                  neg1_reg;
    logic                  neg2_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic [MAG_W-1:0]      rom [0:DEPTH];

    // constant quarter-wave table, both ends included
    for (genvar k = 0; k <= DEPTH; k++)
    begin : g_rom
        assign rom[k] = MAG_W'(tone_entry(k, DEPTH_BITS, SAMPLE_WIDTH));
    end

    // phase accumulator, moves only when the tone is on
    assign phase_next = phase_reg + tone_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (accept && tone_enable)
            phase_reg <= phase_next;
    end

    // quadrant folding onto the quarter table
    assign index     = phase_reg[PHASE_W-3 -: DEPTH_BITS];
    assign addr_next = phase_reg[PHASE_W-2] ? (ADDR_W'(DEPTH) - ADDR_W'(index))
                                            : ADDR_W'(index);

    // address stage, then registered table read
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            addr_reg <= addr_next;
            neg1_reg <= phase_reg[PHASE_W-1];
            mag_reg  <= rom[addr_reg];
            neg2_reg <= neg1_reg;
        end
    end

    // apply the half-wave sign
    always_comb
    begin
        tone = $signed(SAMPLE_WIDTH'(mag_reg));
        if (neg2_reg)
            tone = -tone;
    end

endmodule

// ===== rtl/rtm_mix_lane.sv =====
// rtm_mix_lane: one audio channel, gain by 0.55, tone add, saturation and mode select
// depends on rtm_pkg for the gain constant and the mode flags
`timescale 1ns / 1ps

module rtm_mix_lane
    import rtm_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           advance,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    input  logic signed [SAMPLE_WIDTH-1:0] tone,
    input  mix_ctrl_t                      ctrl,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

    localparam int PROD_W = SAMPLE_WIDTH + 17;
    localparam int SUM_W  = SAMPLE_WIDTH + 2;
    localparam logic signed [PROD_W-1:0] MIX_S   = PROD_W'(MIX_GAIN_Q16);
    localparam logic signed [PROD_W-1:0] ROUND_S = PROD_W'(32768);

    logic signed [SAMPLE_WIDTH-1:0] x1_reg;
    logic signed [SAMPLE_WIDTH-1:0] x2_reg;
    logic signed [PROD_W-1:0]       prod_next;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [SAMPLE_WIDTH:0]   scaled;
    logic signed [SUM_W-1:0]        sum;
    logic signed [SAMPLE_WIDTH-1:0] mixed;

    // scale by the mix gain with rounding
    assign prod_next = PROD_W'(x1_reg) * MIX_S + ROUND_S;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x1_reg   <= sample_in;
            x2_reg   <= x1_reg;
            prod_reg <= prod_next;
        end
    end

    // floor shift, add the tone, clamp to full scale
    assign scaled = prod_reg[PROD_W-1:16];
    assign sum    = SUM_W'(scaled) + SUM_W'(tone);

    always_comb
    begin
        if (sum[SUM_W-1:SAMPLE_WIDTH-1] == '0 || sum[SUM_W-1:SAMPLE_WIDTH-1] == '1)
            mixed = sum[SAMPLE_WIDTH-1:0];
        else if (sum[SUM_W-1])
            mixed = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        else
            mixed = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end

    // mode select
    always_comb
    begin
        if (ctrl.tone_en && ctrl.mute)
            sample_out = tone;
        else if (ctrl.tone_en)
            sample_out = mixed;
        else if (ctrl.mute)
            sample_out = '0;
        else
            sample_out = x2_reg;
    end

endmodule

// ===== rtl/reference_tone_mixer.sv =====
// reference_tone_mixer: top level, config registers, pipeline control, two mix lanes
// depends on rtm_pkg, rtm_tone_gen and rtm_mix_lane
`timescale 1ns / 1ps

// Stereo pass-through with an optional reference sine tone.
// Input channel: in_valid/in_stall carry left_in, right_in and tone_step, one word
// per stereo sample pair. Output channel: out_valid/out_stall carry left_out and
// right_out, one word per input word, in order.
// Configuration: cfg_write with cfg_index selects tone_enable or mute_output and
// takes bit 0 of cfg_data; write only while no word is in flight.
// Pipeline: three register stages from the input accept edge to output valid,
// loaded in order (phase/address stage, registered sine table read and gain
// multiply, then add, clamp and output register).
// Throughput: one word per cycle; the pipeline moves as a whole and only halts
// when the output register holds a word the receiver stalls, in which case
// in_stall is raised in the same cycle.
// Reset clears the tone phase, both config registers and all valid flags;
// the sine table is constant, so there is no start-up pass.

module reference_tone_mixer
    import rtm_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int SAMPLE_WIDTH     = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic                           cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] left_in,
    input  logic signed [SAMPLE_WIDTH-1:0] right_in,
    input  logic [PHASE_W-1:0]             tone_step,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] left_out,
    output logic signed [SAMPLE_WIDTH-1:0] right_out
);

    logic                           tone_enable_reg;
    logic                           mute_output_reg;
    logic                           advance;
    logic                           accept;
    logic                           s1_valid_reg;
    logic                           s2_valid_reg;
    logic                           out_valid_reg;
    mix_ctrl_t                      s1_ctrl_reg;
    mix_ctrl_t                      s2_ctrl_reg;
    logic signed [SAMPLE_WIDTH-1:0] tone;
    logic signed [SAMPLE_WIDTH-1:0] left_mix;
    logic signed [SAMPLE_WIDTH-1:0] right_mix;
    logic signed [SAMPLE_WIDTH-1:0] left_out_reg;
    logic signed [SAMPLE_WIDTH-1:0] right_out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_enable_reg <= 1'b0;
            mute_output_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TONE_ENABLE: tone_enable_reg <= cfg_data;
                REG_MUTE_OUTPUT: mute_output_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // whole pipeline moves unless the output word is held
    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // mode flags travel with each word
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ctrl_reg.tone_en <= tone_enable_reg;
            s1_ctrl_reg.mute    <= mute_output_reg;
            s2_ctrl_reg         <= s1_ctrl_reg;
        end
    end

    // shared tone source
    rtm_tone_gen #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_WIDTH     (SAMPLE_WIDTH)
    ) u_tone_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .accept      (accept),
        .tone_enable (tone_enable_reg),
        .tone_step   (tone_step),
        .tone        (tone)
    );

    // one lane per channel
    rtm_mix_lane #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane_left (
        .clk        (clk),
        .advance    (advance),
        .sample_in  (left_in),
        .tone       (tone),
        .ctrl       (s2_ctrl_reg),
        .sample_out (left_mix)
    );

    rtm_mix_lane #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane_right (
        .clk        (clk),
        .advance    (advance),
        .sample_in  (right_in),
        .tone       (tone),
        .ctrl       (s2_ctrl_reg),
        .sample_out (right_mix)
    );

    // merge both lanes into the output word register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            left_out_reg  <= left_mix;
            right_out_reg <= right_mix;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

`ifndef SYNTHESIS
    // muted without tone gives silence on both channels
    a_mute_silence: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s2_valid_reg && s2_ctrl_reg.mute && !s2_ctrl_reg.tone_en)
        |=> (left_out == '0 && right_out == '0))
        else $error("muted word without tone is not silent");

    // muted with tone gives the same tone on both channels
    a_tone_only_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s2_valid_reg && s2_ctrl_reg.mute && s2_ctrl_reg.tone_en)
        |=> (left_out == right_out))
        else $error("tone-only word differs between channels");

    // an accepted word enters the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted word lost at the first stage");
`endif

endmodule
